// ===== design/bbc_pkg.sv =====
// Shared types and constants for the ball bounce/collision step block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int DEF_MAX_BALLS = 32;
    localparam int DEF_POS_BITS  = 12;
    localparam int RESULT_LIMIT  = 32;

    localparam int IO_POS_W = 12;
    localparam int VEL_W    = 8;
    localparam int RAD_W    = 8;
    localparam int IDX_W    = 5;
    localparam int DIM_W    = 11;
    localparam int CNT_W    = 6;

    localparam logic [DIM_W-1:0] ARENA_W_RST = 11'd800;
    localparam logic [DIM_W-1:0] ARENA_H_RST = 11'd450;
    localparam logic [CNT_W-1:0] ACTIVE_RST  = 6'd20;

    typedef enum logic [1:0] {
        REG_ARENA_W = 2'd0,
        REG_ARENA_H = 2'd1,
        REG_ACTIVE  = 2'd2
    } cfg_reg_t;

    // controller -> datapath
    typedef struct packed {
        logic rd;        // capture both read ports
        logic load;      // write entry from the load fields
        logic move_wr;   // write back moved entry
        logic diff;      // register dx, dy, ra+rb
        logic square;    // register the squares
        logic compare;   // test and write first entry on a hit
        logic swap_b;    // write second entry of a swap
        logic emit;      // register one result item
    } bbc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
    } bbc_stat_t;

endpackage

// ===== design/bbc_ctrl.sv =====
// Sequencer for the tick: move pass, pair pass, emit pass.
// Depends on bbc_pkg; drives bbc_datapath through bbc_cmd_t.
`timescale 1ns / 1ps

module bbc_ctrl
    import bbc_pkg::*;
#(
    parameter int MAX_BALLS = DEF_MAX_BALLS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         command,
    input  logic [CNT_W-1:0]             active_balls,
    input  bbc_stat_t                    stat,
    output logic                         busy,
    output bbc_cmd_t                     cmd,
    output logic [$clog2(MAX_BALLS)-1:0] addr_a,
    output logic [$clog2(MAX_BALLS)-1:0] addr_b,
    output logic                         emit_last
);

    localparam int IW    = $clog2(MAX_BALLS);
    localparam int NW    = $clog2(MAX_BALLS + 1);
    localparam int LIMIT = (MAX_BALLS < RESULT_LIMIT) ? MAX_BALLS : RESULT_LIMIT;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_M_RD   = 10'b00_0000_0010,
        S_M_WR   = 10'b00_0000_0100,
        S_P_RD   = 10'b00_0000_1000,
        S_P_DIFF = 10'b00_0001_0000,
        S_P_SQ   = 10'b00_0010_0000,
        S_P_CMP  = 10'b00_0100_0000,
        S_P_SWB  = 10'b00_1000_0000,
        S_E_RD   = 10'b01_0000_0000,
        S_E_OUT  = 10'b10_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [IW-1:0]   j_reg, j_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [NW-1:0]   n_calc;
    logic            i_is_last;
    logic            j_is_last;
    logic            pairs_done;

    assign n_calc     = (active_balls > CNT_W'(LIMIT)) ? NW'(LIMIT) : NW'(active_balls);
    assign i_is_last  = (NW'(i_reg) == n_reg - NW'(1));
    assign j_is_last  = (NW'(j_reg) == n_reg - NW'(1));
    assign pairs_done = (NW'(i_reg) + NW'(2) == n_reg);

    assign busy      = (state_reg != S_IDLE);
    assign addr_a    = i_reg;
    assign addr_b    = j_reg;
    assign emit_last = i_is_last;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !command)
                begin
                    cmd.load = 1'b1;
                end
                else if (start && command && (n_calc != '0))
                begin
                    n_next     = n_calc;
                    i_next     = '0;
                    state_next = S_M_RD;
                end
            end
            S_M_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_M_WR;
            end
            S_M_WR:
            begin
                cmd.move_wr = 1'b1;
                if (i_is_last)
                begin
                    i_next     = '0;
                    j_next     = IW'(1);
                    state_next = (n_reg == NW'(1)) ? S_E_RD : S_P_RD;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_M_RD;
                end
            end
            S_P_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_P_DIFF;
            end
            S_P_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_P_SQ;
            end
            S_P_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_P_CMP;
            end
            S_P_CMP, S_P_SWB:
            begin
                if (state_reg == S_P_CMP)
                begin
                    cmd.compare = 1'b1;
                end
                else
                begin
                    cmd.swap_b = 1'b1;
                end
                if ((state_reg == S_P_CMP) && stat.hit)
                begin
                    state_next = S_P_SWB;
                end
                else if (!j_is_last)
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_P_RD;
                end
                else if (pairs_done)
                begin
                    i_next     = '0;
                    state_next = S_E_RD;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    j_next     = i_reg + IW'(2);
                    state_next = S_P_RD;
                end
            end
            S_E_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_E_OUT;
            end
            S_E_OUT:
            begin
                cmd.emit = 1'b1;
                if (i_is_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_E_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
        end
    end

endmodule

// ===== design/bbc_datapath.sv =====
// Ball table memory (two registered read ports, one write port), move/bounce
// logic, pair distance test and result registers. Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_datapath
    import bbc_pkg::*;
#(
    parameter int MAX_BALLS = DEF_MAX_BALLS,
    parameter int POS_BITS  = DEF_POS_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bbc_cmd_t                     cmd,
    input  logic [$clog2(MAX_BALLS)-1:0] addr_a,
    input  logic [$clog2(MAX_BALLS)-1:0] addr_b,
    input  logic                         emit_last,
    input  logic [DIM_W-1:0]             arena_width,
    input  logic [DIM_W-1:0]             arena_height,
    input  logic [IDX_W-1:0]             ball_index,
    input  logic signed [IO_POS_W-1:0]   load_pos_x,
    input  logic signed [IO_POS_W-1:0]   load_pos_y,
    input  logic signed [VEL_W-1:0]      load_vel_x,
    input  logic signed [VEL_W-1:0]      load_vel_y,
    input  logic [RAD_W-1:0]             load_radius,
    output bbc_stat_t                    stat,
    output logic                         out_valid,
    output logic [IDX_W-1:0]             out_index,
    output logic signed [IO_POS_W-1:0]   out_pos_x,
    output logic signed [IO_POS_W-1:0]   out_pos_y,
    output logic signed [VEL_W-1:0]      out_vel_x,
    output logic signed [VEL_W-1:0]      out_vel_y,
    output logic                         out_last
);

    localparam int IW     = $clog2(MAX_BALLS);
    localparam int P      = POS_BITS;
    localparam int EW     = POS_BITS + 3;
    localparam int DW     = POS_BITS + 1;
    localparam int SQW    = 2 * DW + 1;
    localparam int RSW    = RAD_W + 1;
    localparam int OFF_R  = 0;
    localparam int OFF_VY = RAD_W;
    localparam int OFF_VX = RAD_W + VEL_W;
    localparam int OFF_PY = RAD_W + 2 * VEL_W;
    localparam int OFF_PX = OFF_PY + P;
    localparam int ENT_W  = OFF_PX + P;

    localparam logic signed [EW-1:0]    PMAX_E  = EW'((1 <<< (P - 1)) - 1);
    localparam logic signed [EW-1:0]    PMIN_E  = -PMAX_E - EW'(1);
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

    function automatic logic signed [P-1:0] sat_pos(input logic signed [EW-1:0] v);
        logic signed [P-1:0] r;
        if (v > PMAX_E)
            r = PMAX_E[P-1:0];
        else if (v < PMIN_E)
            r = PMIN_E[P-1:0];
        else
            r = v[P-1:0];
        return r;
    endfunction

    function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
        return (v == VEL_MIN) ? VEL_MAX : -v;
    endfunction

    // bounce on one axis: far wall first, then near wall with the updated velocity
    function automatic logic signed [VEL_W-1:0] bounce(
        input logic signed [EW-1:0]    p,
        input logic signed [EW-1:0]    r,
        input logic signed [EW-1:0]    wall,
        input logic signed [VEL_W-1:0] v
    );
        logic signed [VEL_W-1:0] v1;
        logic signed [VEL_W-1:0] v2;
        v1 = ((p + r >= wall) && (v > 0)) ? neg_vel(v) : v;
        v2 = ((p - r <= 0) && (v1 < 0)) ? neg_vel(v1) : v1;
        return v2;
    endfunction

    logic [ENT_W-1:0] mem [MAX_BALLS];
    logic [ENT_W-1:0] rd_a_reg;
    logic [ENT_W-1:0] rd_b_reg;

    logic signed [P-1:0]     a_px, a_py, b_px, b_py;
    logic signed [VEL_W-1:0] a_vx, a_vy, b_vx, b_vy;
    logic [RAD_W-1:0]        a_r, b_r;

    logic signed [EW-1:0]    r_e, npx_e, npy_e;
    logic signed [P-1:0]     npx, npy;
    logic signed [VEL_W-1:0] nvx, nvy;
    logic signed [P-1:0]     lpx, lpy;
    logic                    load_ok;

    logic signed [DW-1:0]    dx_reg, dy_reg;
    logic signed [2*DW-1:0]  dx_ext, dy_ext;
    logic [RSW-1:0]          rs_reg;
    logic [2*DW-1:0]         dx2_reg, dy2_reg;
    logic [2*RSW-1:0]        rs2_reg;
    logic                    hit;

    logic                    we;
    logic [IW-1:0]           waddr;
    logic [ENT_W-1:0]        wdata;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_index_reg;
    logic signed [IO_POS_W-1:0] out_pos_x_reg, out_pos_y_reg;
    logic signed [VEL_W-1:0] out_vel_x_reg, out_vel_y_reg;
    logic                    out_last_reg;

    assign a_px = rd_a_reg[OFF_PX +: P];
    assign a_py = rd_a_reg[OFF_PY +: P];
    assign a_vx = rd_a_reg[OFF_VX +: VEL_W];
    assign a_vy = rd_a_reg[OFF_VY +: VEL_W];
    assign a_r  = rd_a_reg[OFF_R  +: RAD_W];
    assign b_px = rd_b_reg[OFF_PX +: P];
    assign b_py = rd_b_reg[OFF_PY +: P];
    assign b_vx = rd_b_reg[OFF_VX +: VEL_W];
    assign b_vy = rd_b_reg[OFF_VY +: VEL_W];
    assign b_r  = rd_b_reg[OFF_R  +: RAD_W];

    // move one ball
    assign r_e   = EW'(a_r);
    assign npx   = sat_pos(EW'(a_px) + EW'(a_vx));
    assign npy   = sat_pos(EW'(a_py) + EW'(a_vy));
    assign npx_e = EW'(npx);
    assign npy_e = EW'(npy);
    assign nvx   = bounce(npx_e, r_e, EW'(arena_width), a_vx);
    assign nvy   = bounce(npy_e, r_e, EW'(arena_height), a_vy);

    assign lpx     = sat_pos(EW'(load_pos_x));
    assign lpy     = sat_pos(EW'(load_pos_y));
    assign load_ok = (32'(ball_index) < MAX_BALLS);

    // differences widened to the full product width before squaring
    assign dx_ext = (2*DW)'(dx_reg);
    assign dy_ext = (2*DW)'(dy_reg);

    assign hit      = (SQW'(dx2_reg) + SQW'(dy2_reg)) < SQW'(rs2_reg);
    assign stat.hit = hit;

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_a;
        wdata = {a_px, a_py, b_vx, b_vy, a_r};
        if (cmd.load)
        begin
            we    = load_ok;
            waddr = IW'(ball_index);
            wdata = {lpx, lpy, load_vel_x, load_vel_y, load_radius};
        end
        else if (cmd.move_wr)
        begin
            we    = 1'b1;
            wdata = {npx, npy, nvx, nvy, a_r};
        end
        else if (cmd.compare)
        begin
            we = hit;
        end
        else if (cmd.swap_b)
        begin
            we    = 1'b1;
            waddr = addr_b;
            wdata = {b_px, b_py, a_vx, a_vy, b_r};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dx_reg <= DW'(a_px) - DW'(b_px);
            dy_reg <= DW'(a_py) - DW'(b_py);
            rs_reg <= RSW'(a_r) + RSW'(b_r);
        end
        if (cmd.square)
        begin
            dx2_reg <= $unsigned(dx_ext * dx_ext);
            dy2_reg <= $unsigned(dy_ext * dy_ext);
            rs2_reg <= rs_reg * rs_reg;
        end
        if (cmd.emit)
        begin
            out_index_reg <= IDX_W'(addr_a);
            out_pos_x_reg <= IO_POS_W'(EW'(a_px));
            out_pos_y_reg <= IO_POS_W'(EW'(a_py));
            out_vel_x_reg <= a_vx;
            out_vel_y_reg <= a_vy;
            out_last_reg  <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_pos_x = out_pos_x_reg;
    assign out_pos_y = out_pos_y_reg;
    assign out_vel_x = out_vel_x_reg;
    assign out_vel_y = out_vel_y_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== design/ball_bounce_collision_step.sv =====
// Top level: APB register file, controller and datapath.
// Depends on bbc_pkg, bbc_ctrl and bbc_datapath.
`timescale 1ns / 1ps

// A load (command 0) writes one ball entry in the cycle it is taken; busy stays
// low. A tick (command 1) with N active balls runs a move pass (read, then write
// back, per ball), then visits every pair i<j (read, difference, square, compare,
// plus a swap state for each pair that swaps velocities), then emits one item
// per ball (read, then output), out_last on the final one. The pair pass
// dominates; it is bound by the single write port of the ball table and the
// register stages of the squared-distance test. Results appear on out_valid for
// one cycle each and cannot be held off. The user must write configuration only
// while busy is low; the block itself does not enforce it.

module ball_bounce_collision_step
    import bbc_pkg::*;
#(
    parameter int MAX_BALLS = DEF_MAX_BALLS,
    parameter int POS_BITS  = DEF_POS_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic                       command,
    input  logic [IDX_W-1:0]           ball_index,
    input  logic signed [IO_POS_W-1:0] load_pos_x,
    input  logic signed [IO_POS_W-1:0] load_pos_y,
    input  logic signed [VEL_W-1:0]    load_vel_x,
    input  logic signed [VEL_W-1:0]    load_vel_y,
    input  logic [RAD_W-1:0]           load_radius,
    output logic                       out_valid,
    output logic [IDX_W-1:0]           out_index,
    output logic signed [IO_POS_W-1:0] out_pos_x,
    output logic signed [IO_POS_W-1:0] out_pos_y,
    output logic signed [VEL_W-1:0]    out_vel_x,
    output logic signed [VEL_W-1:0]    out_vel_y,
    output logic                       out_last
);

    localparam int IW = $clog2(MAX_BALLS);

    logic [DIM_W-1:0] arena_w_reg;
    logic [DIM_W-1:0] arena_h_reg;
    logic [CNT_W-1:0] active_reg;
    logic             cfg_wr;
    cfg_reg_t         cfg_sel;

    bbc_cmd_t         cmd;
    bbc_stat_t        stat;
    logic [IW-1:0]    addr_a;
    logic [IW-1:0]    addr_b;
    logic             emit_last;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_w_reg <= ARENA_W_RST;
            arena_h_reg <= ARENA_H_RST;
            active_reg  <= ACTIVE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_ARENA_W: arena_w_reg <= pwdata[DIM_W-1:0];
                REG_ARENA_H: arena_h_reg <= pwdata[DIM_W-1:0];
                REG_ACTIVE:  active_reg  <= pwdata[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_ARENA_W: prdata = 32'(arena_w_reg);
            REG_ARENA_H: prdata = 32'(arena_h_reg);
            REG_ACTIVE:  prdata = 32'(active_reg);
            default:     prdata = '0;
        endcase
    end

    bbc_ctrl #(
        .MAX_BALLS (MAX_BALLS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .active_balls (active_reg),
        .stat         (stat),
        .busy         (busy),
        .cmd          (cmd),
        .addr_a       (addr_a),
        .addr_b       (addr_b),
        .emit_last    (emit_last)
    );

    bbc_datapath #(
        .MAX_BALLS (MAX_BALLS),
        .POS_BITS  (POS_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .addr_a       (addr_a),
        .addr_b       (addr_b),
        .emit_last    (emit_last),
        .arena_width  (arena_w_reg),
        .arena_height (arena_h_reg),
        .ball_index   (ball_index),
        .load_pos_x   (load_pos_x),
        .load_pos_y   (load_pos_y),
        .load_vel_x   (load_vel_x),
        .load_vel_y   (load_vel_y),
        .load_radius  (load_radius),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_index    (out_index),
        .out_pos_x    (out_pos_x),
        .out_pos_y    (out_pos_y),
        .out_vel_x    (out_vel_x),
        .out_vel_y    (out_vel_y),
        .out_last     (out_last)
    );

`ifndef ASSERT_OFF
    // items are spaced by the emit read state
    a_out_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid)
        else $error("result strobe on consecutive cycles");

    // the final item shows while the block is already free again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |-> !busy)
        else $error("busy still high with final item");

    // a tick with balls to move always starts work
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command && (active_reg != '0)) |=> busy)
        else $error("tick accepted without starting");

    // no result while idle except the final one
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy) |-> out_last)
        else $error("result item outside a tick");
`endif

endmodule
